// ===== rtl/mtel_pkg.sv =====
`timescale 1ns / 1ps

package mtel_pkg;

  // Default encoder resolution in bits per turn.
  localparam int ANGLE_BITS_DEF = 14;

  // Fixed field widths of the result item.
  localparam int POS_W    = 32;
  localparam int TURNS_W  = 18;
  localparam int PART_W   = 15;
  localparam int PLEN_W   = 32;
  localparam int TOTAL_W  = 48;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVERSE   = 2'd0,
    CFG_LEN_COUNT = 2'd1,
    CFG_LEN_TURN  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_ANGLE = 1'b0,
    OP_LIMIT = 1'b1
  } op_t;

  // Position after the state update, handed to the scaling stages.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    zeroed;
  } pos_item_t;

  // Length scale factors, Q16 unsigned.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] per_count;
    logic [CFG_DATA_W-1:0] per_turn;
  } len_cfg_t;

endpackage

// ===== rtl/mtel_in_if.sv =====
`timescale 1ns / 1ps

interface mtel_in_if #(
  parameter int AngleBits = mtel_pkg::ANGLE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [AngleBits-1:0] angle_sample;
  logic                 limit_level;

  modport source (output valid, output operation, output angle_sample,
                  output limit_level, input ready);
  modport sink   (input valid, input operation, input angle_sample,
                  input limit_level, output ready);
endinterface

// ===== rtl/mtel_out_if.sv =====
`timescale 1ns / 1ps

interface mtel_out_if ();
  logic                                     valid;
  logic                                     ready;
  logic signed [mtel_pkg::POS_W-1:0]        position_counts;
  logic signed [mtel_pkg::TURNS_W-1:0]      turns;
  logic signed [mtel_pkg::PART_W-1:0]       partial_angle;
  logic signed [mtel_pkg::PLEN_W-1:0]       partial_length;
  logic signed [mtel_pkg::TOTAL_W-1:0]      total_length;
  logic                                     zeroed;

  modport source (output valid, output position_counts, output turns,
                  output partial_angle, output partial_length,
                  output total_length, output zeroed, input ready);
  modport sink   (input valid, input position_counts, input turns,
                  input partial_angle, input partial_length,
                  input total_length, input zeroed, output ready);
endinterface

// ===== rtl/mtel_scale.sv =====
`timescale 1ns / 1ps

// Splits the position into turns and remainder, scales both to Q16 lengths.
// Two registered stages: split and multiply, then the 48-bit sum.
module mtel_scale #(
  parameter int AngleBits = mtel_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  output logic                s1_ready,
  input  mtel_pkg::pos_item_t s1_item,
  input  mtel_pkg::len_cfg_t  len_cfg,
  mtel_out_if.source          out_item
);

  localparam int TurnW  = mtel_pkg::POS_W - AngleBits;
  localparam int PartIW = AngleBits + 1;
  localparam int CfgXW  = mtel_pkg::CFG_DATA_W + 1;

  logic                 adv2;
  logic                 adv3;
  logic [AngleBits-1:0] low;
  logic                 round_up;
  logic signed [TurnW-1:0]        turns_c;
  logic signed [PartIW-1:0]       part_c;
  logic signed [PartIW+CfgXW-1:0] plen_full;
  logic signed [TurnW+CfgXW-1:0]  tlen_full;

  logic                                   v2_r;
  logic signed [mtel_pkg::POS_W-1:0]      pos2_r;
  logic signed [TurnW-1:0]                turns2_r;
  logic signed [PartIW-1:0]               part2_r;
  logic signed [mtel_pkg::PLEN_W-1:0]     plen2_r;
  logic signed [mtel_pkg::TOTAL_W-1:0]    tlen2_r;
  logic                                   zeroed2_r;

  logic                                   v3_r;
  logic signed [mtel_pkg::TOTAL_W-1:0]    total_nxt;
  logic signed [mtel_pkg::POS_W-1:0]      turns_ext;
  logic signed [mtel_pkg::POS_W-1:0]      part_ext;

  // Each stage moves when it is empty or the next one moves.
  assign adv3     = !v3_r || out_item.ready;
  assign adv2     = !v2_r || adv3;
  assign s1_ready = adv2;

  // Division by a full turn truncated toward zero: an arithmetic shift,
  // then one step back toward zero for a negative value with a remainder.
  always_comb begin
    low      = s1_item.position[AngleBits-1:0];
    round_up = s1_item.position[mtel_pkg::POS_W-1] && (|low);
    turns_c  = s1_item.position[mtel_pkg::POS_W-1:AngleBits] + TurnW'(round_up);
    part_c   = round_up ? $signed({1'b1, low}) : $signed({1'b0, low});
    plen_full = part_c * $signed({1'b0, len_cfg.per_count});
    tlen_full = turns_c * $signed({1'b0, len_cfg.per_turn});
  end

  // Stage two valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= s1_valid;
    end
  end

  // Stage two payload.
  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      pos2_r    <= s1_item.position;
      turns2_r  <= turns_c;
      part2_r   <= part_c;
      plen2_r   <= plen_full[mtel_pkg::PLEN_W-1:0];
      tlen2_r   <= tlen_full[mtel_pkg::TOTAL_W-1:0];
      zeroed2_r <= s1_item.zeroed;
    end
  end

  // Total length adds the already wrapped partial length.
  always_comb begin
    total_nxt = tlen2_r + mtel_pkg::TOTAL_W'(plen2_r);
    turns_ext = mtel_pkg::POS_W'(turns2_r);
    part_ext  = mtel_pkg::POS_W'(part2_r);
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      out_item.position_counts <= pos2_r;
      out_item.turns           <= turns_ext[mtel_pkg::TURNS_W-1:0];
      out_item.partial_angle   <= part_ext[mtel_pkg::PART_W-1:0];
      out_item.partial_length  <= plen2_r;
      out_item.total_length    <= total_nxt;
      out_item.zeroed          <= zeroed2_r;
    end
  end

  assign out_item.valid = v3_r;

  // Turns and remainder rebuild the position exactly.
  assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ($signed({turns2_r, {AngleBits{1'b0}}}) + part_ext) == pos2_r)
    else $error("turns and remainder do not rebuild the position");

  // A nonzero remainder carries the sign of the position.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && part2_r != '0) |-> part2_r[PartIW-1] == pos2_r[mtel_pkg::POS_W-1])
    else $error("remainder sign differs from position sign");

  // A stalled result register keeps its item while stage two waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_item.ready && v2_r) |=> (v2_r && v3_r))
    else $error("item lost during output stall");

endmodule

// ===== rtl/multiturn_encoder_length_tracker.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Handshake      Payload
// in_item    in   valid/ready    operation, angle_sample, limit_level
// out_item   out  valid/ready    position_counts, turns, partial_angle,
//                                partial_length, total_length, zeroed
// cfg_*      in   cfg_wr_en      cfg_index, cfg_wdata (no read-back)
//
// One item is accepted per cycle while in_item.ready is high; its result
// passes through three register stages: state update, split and multiply,
// and the 48-bit total add into the result register.
// Reset (rst_n, synchronous) clears the tracking state, the configuration
// registers and the stage valid flags.
// A stalled output fills the internal stages first; in_item.ready falls
// only when all three stages hold items.
module multiturn_encoder_length_tracker #(
  parameter int ANGLE_BITS = mtel_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mtel_in_if.sink                           in_item,
  mtel_out_if.source                        out_item,
  input  logic                              cfg_wr_en,
  input  logic [mtel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mtel_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [mtel_pkg::POS_W-1:0] TurnCounts =
    mtel_pkg::POS_W'(1) << ANGLE_BITS;

  // Configuration registers.
  logic                 reverse_r;
  mtel_pkg::len_cfg_t   len_cfg_r;

  // Tracking state.
  logic                              limit_prev_r;
  logic                              limit_prev_nxt;
  logic                              seeded_r;
  logic                              seeded_nxt;
  logic [ANGLE_BITS-1:0]             angle_prev_r;
  logic [ANGLE_BITS-1:0]             angle_prev_nxt;
  logic signed [mtel_pkg::POS_W-1:0] acc_r;
  logic signed [mtel_pkg::POS_W-1:0] acc_nxt;

  logic                  accept;
  logic                  s1_ready;
  logic [ANGLE_BITS-1:0] cur;
  logic                  cur_q3;
  logic                  cur_q0;
  logic                  prev_q3;
  logic                  prev_q0;
  logic [mtel_pkg::POS_W-1:0] step;
  logic                  zeroed;

  logic                  s1_valid_r;
  mtel_pkg::pos_item_t   s1_item_r;
  mtel_pkg::pos_item_t   s1_item_nxt;

  assign in_item.ready = !s1_valid_r || s1_ready;
  assign accept        = in_item.valid && in_item.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r <= 1'b0;
      len_cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (mtel_pkg::cfg_reg_t'(cfg_index))
        mtel_pkg::CFG_REVERSE:   reverse_r          <= cfg_wdata[0];
        mtel_pkg::CFG_LEN_COUNT: len_cfg_r.per_count <= cfg_wdata;
        mtel_pkg::CFG_LEN_TURN:  len_cfg_r.per_turn  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Angle step with turn handling across the quadrant 3 / quadrant 0 seam.
  always_comb begin
    cur     = reverse_r ? ~in_item.angle_sample : in_item.angle_sample;
    cur_q3  = cur[ANGLE_BITS-1:ANGLE_BITS-2] == 2'b11;
    cur_q0  = cur[ANGLE_BITS-1:ANGLE_BITS-2] == 2'b00;
    prev_q3 = angle_prev_r[ANGLE_BITS-1:ANGLE_BITS-2] == 2'b11;
    prev_q0 = angle_prev_r[ANGLE_BITS-1:ANGLE_BITS-2] == 2'b00;
    step    = mtel_pkg::POS_W'(cur) - mtel_pkg::POS_W'(angle_prev_r);
    if (cur_q3 && prev_q0) begin
      step = step - TurnCounts;
    end else if (cur_q0 && prev_q3) begin
      step = step + TurnCounts;
    end
  end

  // State update for one accepted item.
  always_comb begin
    limit_prev_nxt = limit_prev_r;
    seeded_nxt     = seeded_r;
    angle_prev_nxt = angle_prev_r;
    acc_nxt        = acc_r;
    zeroed         = 1'b0;
    if (accept) begin
      if (mtel_pkg::op_t'(in_item.operation) == mtel_pkg::OP_LIMIT) begin
        // A falling edge of the limit switch clears the position.
        if (limit_prev_r && !in_item.limit_level) begin
          acc_nxt = '0;
          zeroed  = 1'b1;
        end
        limit_prev_nxt = in_item.limit_level;
      end else begin
        // The first sample only seeds the previous angle.
        if (seeded_r) begin
          acc_nxt = acc_r + $signed(step);
        end
        seeded_nxt     = 1'b1;
        angle_prev_nxt = cur;
      end
    end
    s1_item_nxt.position = acc_nxt;
    s1_item_nxt.zeroed   = zeroed;
  end

  // Tracking state and stage one valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_prev_r <= 1'b0;
      seeded_r     <= 1'b0;
      angle_prev_r <= '0;
      acc_r        <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      limit_prev_r <= limit_prev_nxt;
      seeded_r     <= seeded_nxt;
      angle_prev_r <= angle_prev_nxt;
      acc_r        <= acc_nxt;
      if (in_item.ready) begin
        s1_valid_r <= accept;
      end
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  mtel_scale #(
    .AngleBits (ANGLE_BITS)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_ready (s1_ready),
    .s1_item  (s1_item_r),
    .len_cfg  (len_cfg_r),
    .out_item (out_item)
  );

  // A clearing item reports a zero position.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_item_r.zeroed) |-> s1_item_r.position == '0)
    else $error("zeroed item with nonzero position");

  // Once seeded, the tracker stays seeded until reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped without reset");

  // Angle samples never report a limit clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.operation == mtel_pkg::OP_ANGLE) |=> !s1_item_r.zeroed)
    else $error("angle sample flagged as zeroed");

  // The seeding sample leaves the position unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.operation == mtel_pkg::OP_ANGLE && !seeded_r)
      |=> s1_item_r.position == $past(acc_r))
    else $error("seeding sample moved the position");

endmodule

// ===== test/multiturn_encoder_length_tracker_tb.sv =====
`timescale 1ns / 1ps

module multiturn_encoder_length_tracker_tb;

  localparam int ANGLE_W = mtel_pkg::ANGLE_BITS_DEF;
  localparam logic [ANGLE_W-1:0] ANGLE_FULL = '1;
  localparam longint TURN_COUNTS = longint'(1) << ANGLE_W;
  localparam logic [1:0] QUAD_TOP = 2'b11;
  localparam logic [1:0] QUAD_BOTTOM = 2'b00;

  // About 1,300 items finish well within this limit, even under the longest
  // gaps and stalls.
  localparam int unsigned CYCLE_LIMIT = 250_000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 220;
  // One lap is one turn; the reverse laps take the position below zero.
  localparam int FORWARD_LAPS = 20;
  localparam int REVERSE_LAPS = 40;

  typedef struct packed {
    logic [mtel_pkg::POS_W-1:0]   position;
    logic [mtel_pkg::TURNS_W-1:0] turns;
    logic [mtel_pkg::PART_W-1:0]  part_angle;
    logic [mtel_pkg::PLEN_W-1:0]  part_length;
    logic [mtel_pkg::TOTAL_W-1:0] total_length;
    logic                         zeroed;
  } tracker_reading_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [mtel_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mtel_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mtel_in_if #(.AngleBits(ANGLE_W)) in_ch ();
  mtel_out_if out_ch ();

  multiturn_encoder_length_tracker #(
    .ANGLE_BITS(ANGLE_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the registers and the tracking state.
  logic               mirror_angle;
  logic [31:0]        scale_per_count;
  logic [31:0]        scale_per_turn;
  logic               limit_last;
  logic               seeded_flag;
  logic [ANGLE_W-1:0] angle_last;
  logic [31:0]        position_acc;

  tracker_reading_t   expected_readings[$];
  bit                 idle_en;
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  int                 stall_left = 0;
  logic [ANGLE_W-1:0] walk_angle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[multiturn_encoder_length_tracker] ERROR");
      $finish;
    end
  end

  // Result side: ready drops in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Applies one accepted item to the shadow state and queues the reading it should produce.
  task automatic advance_tracker(mtel_pkg::op_t op, logic [ANGLE_W-1:0] angle, logic level);
    tracker_reading_t reading;
    logic [ANGLE_W-1:0] cur;
    longint pos;
    longint whole_turns;
    longint part;
    longint total;
    logic [31:0] part_len;
    reading.zeroed = 1'b0;
    if (op == mtel_pkg::OP_LIMIT) begin
      // A falling edge of the switch clears the position only.
      if (limit_last && !level) begin
        position_acc = '0;
        reading.zeroed = 1'b1;
      end
      limit_last = level;
    end else begin
      cur = mirror_angle ? ANGLE_FULL - angle : angle;
      if (!seeded_flag) begin
        seeded_flag = 1'b1;
      end else if (cur[ANGLE_W-1 -: 2] == QUAD_TOP &&
                   angle_last[ANGLE_W-1 -: 2] == QUAD_BOTTOM) begin
        position_acc = position_acc - (32'(TURN_COUNTS) - 32'(cur) + 32'(angle_last));
      end else if (cur[ANGLE_W-1 -: 2] == QUAD_BOTTOM &&
                   angle_last[ANGLE_W-1 -: 2] == QUAD_TOP) begin
        position_acc = position_acc + 32'(cur) + 32'(TURN_COUNTS) - 32'(angle_last);
      end else begin
        position_acc = position_acc + 32'(cur) - 32'(angle_last);
      end
      angle_last = cur;
    end

    // Division and remainder truncate toward zero; products keep their low bits.
    pos = longint'($signed(position_acc));
    whole_turns = pos / TURN_COUNTS;
    part = pos % TURN_COUNTS;
    part_len = 32'(part * longint'({32'd0, scale_per_count}));
    total = whole_turns * longint'({32'd0, scale_per_turn}) + longint'($signed(part_len));

    reading.position = position_acc;
    reading.turns = whole_turns[mtel_pkg::TURNS_W-1:0];
    reading.part_angle = part[mtel_pkg::PART_W-1:0];
    reading.part_length = part_len;
    reading.total_length = total[mtel_pkg::TOTAL_W-1:0];
    expected_readings.push_back(reading);
  endtask

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endfunction

  // Each accepted result is compared with the oldest queued reading.
  always @(posedge clk) begin
    tracker_reading_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_readings.size() == 0) begin
        error_count++;
        $error("result item arrived with no reading expected");
      end else begin
        want = expected_readings.pop_front();
        check_field("position_counts", want.position, $unsigned(out_ch.position_counts));
        check_field("turns", want.turns, $unsigned(out_ch.turns));
        check_field("partial_angle", want.part_angle, $unsigned(out_ch.partial_angle));
        check_field("partial_length", want.part_length, $unsigned(out_ch.partial_length));
        check_field("total_length", want.total_length, $unsigned(out_ch.total_length));
        check_field("zeroed", want.zeroed, out_ch.zeroed);
      end
    end
  end

  // Presents one item, with an optional gap before it, and waits until it is taken.
  task automatic send_item(mtel_pkg::op_t op, logic [ANGLE_W-1:0] angle, logic level);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.operation <= op;
    in_ch.angle_sample <= angle;
    in_ch.limit_level <= level;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    advance_tracker(op, angle, level);
  endtask

  // The unused field of each item carries random bits.
  task automatic send_angle(logic [ANGLE_W-1:0] angle);
    send_item(mtel_pkg::OP_ANGLE, angle, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_limit(logic level);
    send_item(mtel_pkg::OP_LIMIT, ANGLE_W'($urandom_range(0, ANGLE_FULL)), level);
  endtask

  // Stops sending and waits until every queued reading has come back.
  task automatic wait_readings_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(mtel_pkg::cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      mtel_pkg::CFG_REVERSE:   mirror_angle = value[0];
      mtel_pkg::CFG_LEN_COUNT: scale_per_count = value;
      mtel_pkg::CFG_LEN_TURN:  scale_per_turn = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Upper bits of the direction write are random; only bit 0 matters.
  task automatic set_scales(logic reverse, logic [31:0] per_count, logic [31:0] per_turn);
    write_register(mtel_pkg::CFG_REVERSE, {31'($urandom()), reverse});
    write_register(mtel_pkg::CFG_LEN_COUNT, per_count);
    write_register(mtel_pkg::CFG_LEN_TURN, per_turn);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(1, 32'h0002_0000));
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed_cases();
    // Registers still hold reset values, so all lengths come out zero.
    send_angle(14'd100);
    send_angle(14'd300);
    send_limit(1'b1);
    send_limit(1'b0);
    send_limit(1'b0);
    wait_readings_drained();

    // Both quadrant crossings in each direction, with unit scales.
    set_scales(1'b0, 32'h0001_0000, 32'h4000_0000);
    send_angle(ANGLE_FULL);
    send_angle('0);
    send_angle(14'h3000);
    send_angle(14'h0FFF);
    send_angle(14'h2000);
    send_angle(14'h0001);
    // A switch edge between samples clears only the position.
    send_limit(1'b1);
    send_angle(14'd5000);
    send_limit(1'b0);
    wait_readings_drained();

    // Mirrored samples with the largest scales, so both lengths wrap.
    set_scales(1'b1, '1, '1);
    send_angle('0);
    send_angle(ANGLE_FULL);
    send_angle(14'h1555);
    send_angle(14'h3AAA);
    send_limit(1'b0);
    send_limit(1'b0);
  endtask

  task automatic test_random_traffic();
    int pick;
    int stride;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_readings_drained();
      idle_en = (phase != 2);
      set_scales(phase[0], pick_scale(), pick_scale());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_limit(1'($urandom_range(0, 1)));
        end else if (pick < 30) begin
          send_angle(ANGLE_W'($urandom_range(0, ANGLE_FULL)));
        end else begin
          // Mostly a walk in small steps, which keeps crossing quadrant boundaries.
          if (pick < 40)
            stride = int'($urandom_range(0, 16382)) - 8191;
          else
            stride = int'($urandom_range(0, 4095)) - 2048;
          walk_angle = walk_angle + stride[ANGLE_W-1:0];
          send_angle(walk_angle);
        end
        // Pause now and then until every reading is back.
        if (n == PHASE_ITEMS / 2 || $urandom_range(0, 59) == 0)
          wait_readings_drained();
      end
    end
  endtask

  task automatic test_full_rate_laps();
    wait_readings_drained();
    idle_en = 1'b0;
    set_scales(1'b0, '1, '1);
    send_angle(14'd4000);
    send_limit(1'b1);
    send_limit(1'b0);
    // Quadrant 0, 1, 3 and back: each lap adds one turn, give or take the jitter.
    for (int lap = 0; lap < FORWARD_LAPS; lap++) begin
      send_angle(14'(4096 + $urandom_range(0, 511)));
      send_angle(14'(15872 + $urandom_range(0, 511)));
      send_angle(14'(3584 + $urandom_range(0, 511)));
    end
    // Reverse laps take the position back through zero to negative turns.
    for (int lap = 0; lap < REVERSE_LAPS; lap++) begin
      send_angle(14'(15872 + $urandom_range(0, 511)));
      send_angle(14'(4096 + $urandom_range(0, 511)));
      send_angle(14'(3584 + $urandom_range(0, 511)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.angle_sample = '0;
    in_ch.limit_level = 1'b0;
    mirror_angle = 1'b0;
    scale_per_count = '0;
    scale_per_turn = '0;
    limit_last = 1'b0;
    seeded_flag = 1'b0;
    angle_last = '0;
    position_acc = '0;
    walk_angle = '0;
    idle_en = 1'b1;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_full_rate_laps();

    // Let any stray result show up before the verdict.
    wait_readings_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("[multiturn_encoder_length_tracker] OK");
    else
      $display("[multiturn_encoder_length_tracker] ERROR");
    $finish;
  end

endmodule
